[design/zcfm_pkg.sv]
// package with widths, register codes and sequencer states of the zero-cross frequency meter
`timescale 1ns / 1ps
package zcfm_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int COUNT_BITS    = 20;
	localparam int FRACTION_BITS = 16;
	localparam int RATE_BITS     = 16;
	localparam int FREQ_BITS     = 24;
	localparam int PERIOD_BITS   = 36;
	localparam int FRAC_W        = FRACTION_BITS + 1;
	localparam int GROSS_BITS    = COUNT_BITS + FRACTION_BITS + 1;
	localparam int REM_BITS      = PERIOD_BITS + 1;
	localparam int STEP_BITS     = $clog2(FREQ_BITS + 1);
	localparam int ADDR_BITS     = 3;
	localparam int DATA_BITS     = 32;
	localparam int OUT_BYTES     = (FREQ_BITS + PERIOD_BITS + 7) / 8;
	localparam int OUT_DATA_BITS = OUT_BYTES * 8;

	localparam logic [RATE_BITS-1:0] SAMPLE_RATE_RESET = RATE_BITS'(44117);

	// register index, taken from paddr[2]
	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_RATE   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FRAC,
		ST_PERIOD,
		ST_CHECK,
		ST_FREQ,
		ST_OUT
	} state_t;

endpackage

[design/zero_cross_frequency_meter.sv]
// zero-cross frequency meter: crossing detect, bit-serial divider and result register
`timescale 1ns / 1ps
// Zero-crossing frequency meter.
// Input stream s_*: one signed 16-bit audio sample per word. Samples are always
// accepted when the sequencer is idle; with transmit_enable clear they are dropped
// and all measurement state is held.
// Output stream m_*: one word per rising zero crossing (previous <= 0, current > 0)
// carrying the frequency in 1/256 Hz and the interpolated period in Q20.16 samples.
// APB port: register 0 at byte 0 is transmit_enable, register 1 at byte 4 is
// sample_rate. Writes land on the access cycle, pready is tied high.
// A sample that is no crossing does not hold the input; the next can follow at once.
// A crossing holds s_tready low while it uses the one-bit-per-cycle divider: 16 steps
// for the fraction (skipped when the previous sample is exactly zero), the period,
// the saturation check (skipped for a period that is not positive), 24 steps for the
// frequency (skipped unless the period exceeds sample_rate), then the result load.
// The result register is separate, so samples keep flowing while a result waits;
// only a second crossing stalls, in its load state, until m_tready frees it.
// Reset clears the sample counter, the stored sample and fraction, transmit_enable and
// sets sample_rate to 44117.
module zero_cross_frequency_meter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [zcfm_pkg::SAMPLE_BITS-1:0]     s_tdata,  // [15:0] sample
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [zcfm_pkg::OUT_DATA_BITS-1:0]   m_tdata,  // [23:0] frequency, [59:24] period
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [zcfm_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [zcfm_pkg::DATA_BITS-1:0]       pwdata,
	output logic [zcfm_pkg::DATA_BITS-1:0]       prdata,
	output logic                                 pready
);
	import zcfm_pkg::*;

	state_t                    state_q, state_d;
	logic                      enable_q;
	logic [RATE_BITS-1:0]      rate_q;
	logic [COUNT_BITS-1:0]     count_q;
	logic [SAMPLE_BITS-1:0]    prev_q;
	logic [FRAC_W-1:0]         prev_frac_q;
	logic [REM_BITS-1:0]       rem_q;
	logic [PERIOD_BITS-1:0]    div_q;
	logic [FREQ_BITS-1:0]      quo_q;
	logic [STEP_BITS-1:0]      step_q;
	logic                      out_valid_q;
	logic [FREQ_BITS-1:0]      out_freq_q;
	logic [PERIOD_BITS-1:0]    out_period_q;

	logic                      accept;
	logic                      crossing;
	logic [SAMPLE_BITS:0]      spread;
	logic [REM_BITS-1:0]       rem_shift;
	logic                      rem_ge;
	logic [GROSS_BITS-1:0]     gross;
	logic [GROSS_BITS-1:0]     frac_ext;
	logic [GROSS_BITS-1:0]     diff;
	logic                      out_free;
	logic                      cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_RATE) ?
		{{(DATA_BITS-RATE_BITS){1'b0}}, rate_q} : {{(DATA_BITS-1){1'b0}}, enable_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			rate_q   <= SAMPLE_RATE_RESET;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_ENABLE: enable_q <= pwdata[0];
				REG_RATE:   rate_q   <= pwdata[RATE_BITS-1:0];
				default:    ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	// previous <= 0 and current > 0
	assign crossing = (prev_q[SAMPLE_BITS-1] || (prev_q == '0)) &&
		!s_tdata[SAMPLE_BITS-1] && (s_tdata != '0);
	assign spread   = {s_tdata[SAMPLE_BITS-1], s_tdata} - {prev_q[SAMPLE_BITS-1], prev_q};

	// one restoring division step, shared by fraction and frequency
	assign rem_shift = {rem_q[REM_BITS-2:0], 1'b0};
	assign rem_ge    = rem_shift >= {1'b0, div_q};

	assign gross    = {1'b0, count_q, {FRACTION_BITS{1'b0}}} +
		{{(GROSS_BITS-FRAC_W){1'b0}}, prev_frac_q};
	assign frac_ext = {{(GROSS_BITS-FRAC_W){1'b0}}, quo_q[FRAC_W-1:0]};
	assign diff     = gross - frac_ext;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && enable_q && crossing)
					state_d = (prev_q == '0) ? ST_PERIOD : ST_FRAC;
			end
			ST_FRAC: begin
				if (step_q == STEP_BITS'(1))
					state_d = ST_PERIOD;
			end
			ST_PERIOD: begin
				state_d = (gross > frac_ext) ? ST_CHECK : ST_OUT;
			end
			ST_CHECK: begin
				state_d = (div_q <= {{(PERIOD_BITS-RATE_BITS){1'b0}}, rate_q}) ?
					ST_OUT : ST_FREQ;
			end
			ST_FREQ: begin
				if (step_q == STEP_BITS'(1))
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			prev_q      <= '0;
			prev_frac_q <= '0;
		end else if (accept && enable_q) begin
			prev_q <= s_tdata;
			if (count_q != '1)
				count_q <= count_q + COUNT_BITS'(1);
		end else if (state_q == ST_PERIOD) begin
			prev_frac_q <= quo_q[FRAC_W-1:0];
			count_q     <= '0;
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				div_q  <= {{(PERIOD_BITS-SAMPLE_BITS-1){1'b0}}, spread};
				rem_q  <= {{(REM_BITS-SAMPLE_BITS){1'b0}}, s_tdata};
				step_q <= STEP_BITS'(FRACTION_BITS);
				// a zero previous sample gives a fraction of exactly one
				if (prev_q == '0)
					quo_q <= FREQ_BITS'(1) << FRACTION_BITS;
				else
					quo_q <= '0;
			end
			ST_FRAC, ST_FREQ: begin
				rem_q  <= rem_ge ? (rem_shift - {1'b0, div_q}) : rem_shift;
				quo_q  <= {quo_q[FREQ_BITS-2:0], rem_ge};
				step_q <= step_q - STEP_BITS'(1);
			end
			ST_PERIOD: begin
				if (gross > frac_ext) begin
					div_q <= diff[GROSS_BITS-1] ? '1 : diff[PERIOD_BITS-1:0];
				end else begin
					div_q <= '0;
					quo_q <= '1;
				end
			end
			ST_CHECK: begin
				rem_q  <= {{(REM_BITS-RATE_BITS){1'b0}}, rate_q};
				step_q <= STEP_BITS'(FREQ_BITS);
				if (div_q <= {{(PERIOD_BITS-RATE_BITS){1'b0}}, rate_q})
					quo_q <= '1;
				else
					quo_q <= '0;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_OUT && out_free)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_freq_q   <= quo_q;
			out_period_q <= div_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_BITS-FREQ_BITS-PERIOD_BITS){1'b0}}, out_period_q, out_freq_q};

`ifndef SYNTHESIS
	// remainder stays below the divisor while the frequency bits come out
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FREQ |-> rem_q < {1'b0, div_q})
		else $error("divider remainder not below divisor");

	// the sample count restarts after every crossing
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PERIOD |=> count_q == '0)
		else $error("sample count not cleared after crossing");

	// a new result only comes from the load state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_OUT))
		else $error("result word raised outside load state");

	// an enabled crossing blocks the input until its result is loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && enable_q && crossing) |=> !s_tready)
		else $error("input accepted during division");
`endif

endmodule
